/* rtl/core/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the skeleton matrix composer: item
// structs, matrix and column types, operation codes and result FIFO sizing.
// ----------------------------------------------------------------------------
package smc_pkg;

    // Result FIFO sizing; it must hold every result that can be in flight.
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned FIFO_CW    = 4;

    // Operation codes of an input item.
    localparam logic OP_ANCESTOR = 1'b0;
    localparam logic OP_BONE     = 1'b1;

    // The translation column closes a bone.
    localparam logic [1:0] COL_TRANSLATION = 2'd3;

    // Bone index reported for an item past the bone limit.
    localparam logic [5:0] LIMIT_BONE = 6'd63;

    typedef logic signed [31:0] word_t;

    // One matrix column, element [r] is row r.
    typedef word_t [3:0] vec_t;

    // One 4x4 matrix, element [k] is column k.
    typedef vec_t [3:0] mat_t;

    typedef struct packed {
        logic        op;
        logic [1:0]  column;
        word_t       e0;
        word_t       e1;
        word_t       e2;
        word_t       e3;
        logic        push_req;
        logic        pop_req;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  bone;
        logic [1:0]  out_column;
        word_t       c0;
        word_t       c1;
        word_t       c2;
        word_t       c3;
        logic        stack_error;
    } out_item_t;

endpackage

/* rtl/core/smc_column_mac.sv */
// ----------------------------------------------------------------------------
// smc_column_mac
// Fixed-latency datapath computing one model column as parent matrix times
// local column, in signed fixed point with round-half-up and saturation.
// ----------------------------------------------------------------------------
module smc_column_mac #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          aclk,
    input  smc_pkg::mat_t par,
    input  smc_pkg::vec_t col_vec,
    output smc_pkg::vec_t res_reg
);

    localparam logic signed [65:0] ROUND  = 66'sd1 << (FRAC_BITS - 1);
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    logic signed [63:0] prod_reg [4][4];
    logic signed [64:0] pair_reg [4][2];
    logic signed [65:0] sum      [4];
    logic signed [65:0] shifted  [4];
    smc_pkg::vec_t      res_next;

    // Stage one: sixteen full products, [row][column of the parent].
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                prod_reg[r][k] <= $signed(par[k][r]) * $signed(col_vec[k]);
            end
        end
    end

    // Stage two: pairwise sums of the products of each row.
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 4; r++) begin
            pair_reg[r][0] <= $signed({prod_reg[r][0][63], prod_reg[r][0]})
                            + $signed({prod_reg[r][1][63], prod_reg[r][1]});
            pair_reg[r][1] <= $signed({prod_reg[r][2][63], prod_reg[r][2]})
                            + $signed({prod_reg[r][3][63], prod_reg[r][3]});
        end
    end

    // Stage three: final sum, round to nearest, drop the fraction, saturate.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum[r] = $signed({pair_reg[r][0][64], pair_reg[r][0]})
                   + $signed({pair_reg[r][1][64], pair_reg[r][1]}) + ROUND;
            shifted[r] = sum[r] >>> FRAC_BITS;
            if (shifted[r] > SAT_HI) begin
                res_next[r] = 32'sh7fffffff;
            end else if (shifted[r] < SAT_LO) begin
                res_next[r] = 32'sh80000000;
            end else begin
                res_next[r] = shifted[r][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

/* rtl/core/smc_result_fifo.sv */
// ----------------------------------------------------------------------------
// smc_result_fifo
// Small result FIFO that decouples the compute pipeline from the output
// handshake; the producer never pushes into a full FIFO.
// ----------------------------------------------------------------------------
module smc_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  smc_pkg::out_item_t  push_data,
    input  logic                pop,
    output logic                out_valid,
    output smc_pkg::out_item_t  out_data
);

    smc_pkg::out_item_t                 fifo_mem [smc_pkg::FIFO_DEPTH];
    logic [smc_pkg::FIFO_AW-1:0]        wr_ptr_reg;
    logic [smc_pkg::FIFO_AW-1:0]        rd_ptr_reg;
    logic [smc_pkg::FIFO_CW-1:0]        count_reg;
    logic                               do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    // Storage for queued results.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + smc_pkg::FIFO_CW'(push)
                       - smc_pkg::FIFO_CW'(do_pop);
        end
    end

endmodule

/* rtl/core/skeleton_matrix_compose.sv */
// Throughput: one item per cycle while the parent's matrix is settled in memory
// and the result FIFO has room. A bone item's result enters the FIFO from the
// last stage of the four-stage compute pipeline; a bone whose parent still has
// columns in it waits until the parent's last column is written.
// Reset: synchronous active-low aresetn; identity ancestor, root on the
// stack, no bones, empty result FIFO. The model memory needs no clearing.
// ----------------------------------------------------------------------------
// skeleton_matrix_compose
// Composes bone-local matrices into model-space matrices, one column per
// item, with a parent stack that follows the skeleton hierarchy.
// ----------------------------------------------------------------------------
module skeleton_matrix_compose #(
    parameter int unsigned MAX_BONES   = 64,
    parameter int unsigned STACK_DEPTH = 64,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smc_pkg::out_item_t  m_data
);

    localparam int unsigned BW  = $clog2(MAX_BONES);
    localparam int unsigned CW  = $clog2(MAX_BONES + 1);
    localparam int unsigned SAW = $clog2(STACK_DEPTH);
    localparam int unsigned LW  = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] BONE_LIMIT = CW'(MAX_BONES);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    typedef struct packed {
        logic          vld;
        logic          wr;
        logic          lim;
        logic          err;
        logic [BW-1:0] bone;
        logic [1:0]    col;
    } tag_t;

    // Control state.
    logic [CW-1:0]  bone_count_reg,  bone_count_next;
    logic [LW-1:0]  stack_level_reg, stack_level_next;
    logic [BW-1:0]  parent_bone_reg, parent_bone_next;
    logic           pop_pending_reg, pop_pending_next;
    logic           pop_zero_reg,    pop_zero_next;
    logic           root_entry_reg,  root_entry_next;
    logic [smc_pkg::FIFO_CW-1:0] out_cnt_reg, out_cnt_next;

    // Parent stack memory.
    logic [BW-1:0]  stack_mem [STACK_DEPTH];
    logic [BW-1:0]  stack_rdata_reg;
    logic           stack_we;
    logic           stack_re;
    logic [LW-1:0]  level_dec;

    // Item decode.
    logic           s_fire;
    logic           bone_fire;
    logic           load_fire;
    logic           in_limit;
    logic [BW-1:0]  cur_bone;
    logic [BW-1:0]  parent_eff;
    logic           push_ok;
    logic           item_err;
    logic           hazard;

    // Datapath.
    smc_pkg::mat_t  anc_reg;
    smc_pkg::mat_t  bank_rd_reg;
    smc_pkg::mat_t  par;
    smc_pkg::vec_t  e_s1_reg;
    smc_pkg::vec_t  mac_res;
    logic           anc_s1_reg;
    tag_t           tag_s1_reg, tag_s2_reg, tag_s3_reg, tag_s4_reg;
    smc_pkg::out_item_t result;

    assign s_fire    = s_valid && s_ready;
    assign bone_fire = s_fire && (s_data.op == smc_pkg::OP_BONE);
    assign load_fire = s_fire && (s_data.op == smc_pkg::OP_ANCESTOR);
    assign in_limit  = (bone_count_reg >= BONE_LIMIT);
    assign cur_bone  = bone_count_reg[BW-1:0];
    assign level_dec = stack_level_reg - LW'(1);

    // A pop resolves in the next cycle, once the stack read has returned.
    assign parent_eff = pop_pending_reg ? (pop_zero_reg ? '0 : stack_rdata_reg)
                                        : parent_bone_reg;

    // Hold off a bone item while any column of its parent is still in flight.
    assign hazard = (bone_count_reg != '0) && !in_limit && (
          (tag_s1_reg.vld && tag_s1_reg.wr && (tag_s1_reg.bone == parent_eff))
       || (tag_s2_reg.vld && tag_s2_reg.wr && (tag_s2_reg.bone == parent_eff))
       || (tag_s3_reg.vld && tag_s3_reg.wr && (tag_s3_reg.bone == parent_eff))
       || (tag_s4_reg.vld && tag_s4_reg.wr && (tag_s4_reg.bone == parent_eff)));

    assign s_ready = (out_cnt_reg < smc_pkg::FIFO_CW'(smc_pkg::FIFO_DEPTH)) && !hazard;

    // Bone counter and parent stack bookkeeping.
    always_comb begin
        bone_count_next  = bone_count_reg;
        stack_level_next = stack_level_reg;
        parent_bone_next = parent_eff;
        pop_pending_next = 1'b0;
        pop_zero_next    = pop_zero_reg;
        root_entry_next  = root_entry_reg;
        stack_we         = 1'b0;
        stack_re         = 1'b0;
        push_ok          = 1'b0;
        item_err         = 1'b0;
        if (load_fire) begin
            bone_count_next  = '0;
            stack_level_next = LW'(1);
            parent_bone_next = '0;
            root_entry_next  = 1'b1;
        end else if (bone_fire && !in_limit
                     && (s_data.column == smc_pkg::COL_TRANSLATION)) begin
            bone_count_next = bone_count_reg + CW'(1);
            if (cur_bone != '0) begin
                push_ok  = s_data.push_req && (stack_level_reg < LEVEL_FULL);
                item_err = s_data.push_req && !push_ok;
                stack_we = push_ok;
                if (push_ok && (stack_level_reg == '0)) begin
                    root_entry_next = 1'b0;
                end
                if (s_data.pop_req) begin
                    if (push_ok) begin
                        // The pop takes back the parent that was just saved.
                        parent_bone_next = parent_eff;
                    end else if (stack_level_reg == '0) begin
                        item_err         = 1'b1;
                        parent_bone_next = cur_bone;
                    end else begin
                        stack_re         = 1'b1;
                        stack_level_next = level_dec;
                        pop_pending_next = 1'b1;
                        pop_zero_next    = root_entry_reg && (level_dec == '0);
                    end
                end else begin
                    parent_bone_next = cur_bone;
                    stack_level_next = stack_level_reg + LW'(push_ok);
                end
            end
        end
    end

    // Outstanding results, bounded by the FIFO depth.
    always_comb begin
        out_cnt_next = out_cnt_reg + smc_pkg::FIFO_CW'(bone_fire)
                     - smc_pkg::FIFO_CW'(m_valid && m_ready);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg  <= '0;
            stack_level_reg <= LW'(1);
            parent_bone_reg <= '0;
            pop_pending_reg <= 1'b0;
            pop_zero_reg    <= 1'b0;
            root_entry_reg  <= 1'b1;
            out_cnt_reg     <= '0;
        end else begin
            bone_count_reg  <= bone_count_next;
            stack_level_reg <= stack_level_next;
            parent_bone_reg <= parent_bone_next;
            pop_pending_reg <= pop_pending_next;
            pop_zero_reg    <= pop_zero_next;
            root_entry_reg  <= root_entry_next;
            out_cnt_reg     <= out_cnt_next;
        end
    end

    // Parent stack memory, one write and one read port.
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_level_reg[SAW-1:0]] <= parent_eff;
        end
        if (stack_re) begin
            stack_rdata_reg <= stack_mem[level_dec[SAW-1:0]];
        end
    end

    // Ancestor matrix, identity after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                for (int r = 0; r < 4; r++) begin
                    anc_reg[k][r] <= (k == r) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
                end
            end
        end else if (load_fire) begin
            anc_reg[s_data.column] <= {s_data.e3, s_data.e2, s_data.e1, s_data.e0};
        end
    end

    // Model matrix memory: one bank per column, wide read of the parent.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        smc_pkg::vec_t bank_mem [MAX_BONES];

        always_ff @(posedge aclk) begin
            if (tag_s4_reg.vld && tag_s4_reg.wr && (tag_s4_reg.col == 2'(b))) begin
                bank_mem[tag_s4_reg.bone] <= mac_res;
            end
            bank_rd_reg[b] <= bank_mem[parent_eff];
        end
    end

    // Operand stage: local column and the source of the parent matrix.
    always_ff @(posedge aclk) begin
        e_s1_reg   <= {s_data.e3, s_data.e2, s_data.e1, s_data.e0};
        anc_s1_reg <= (bone_count_reg == '0);
    end

    assign par = anc_s1_reg ? anc_reg : bank_rd_reg;

    // Item tags that travel alongside the compute pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
        end else begin
            tag_s1_reg.vld  <= bone_fire;
            tag_s1_reg.wr   <= !in_limit;
            tag_s1_reg.lim  <= in_limit;
            tag_s1_reg.err  <= in_limit || item_err;
            tag_s1_reg.bone <= cur_bone;
            tag_s1_reg.col  <= s_data.column;
            tag_s2_reg      <= tag_s1_reg;
            tag_s3_reg      <= tag_s2_reg;
            tag_s4_reg      <= tag_s3_reg;
        end
    end

    smc_column_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .par     (par),
        .col_vec (e_s1_reg),
        .res_reg (mac_res)
    );

    // Result item; an item past the bone limit reports zeros.
    always_comb begin
        result.bone        = tag_s4_reg.lim ? smc_pkg::LIMIT_BONE : 6'(tag_s4_reg.bone);
        result.out_column  = tag_s4_reg.col;
        result.c0          = tag_s4_reg.lim ? 32'sd0 : mac_res[0];
        result.c1          = tag_s4_reg.lim ? 32'sd0 : mac_res[1];
        result.c2          = tag_s4_reg.lim ? 32'sd0 : mac_res[2];
        result.c3          = tag_s4_reg.lim ? 32'sd0 : mac_res[3];
        result.stack_error = tag_s4_reg.err;
    end

    smc_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tag_s4_reg.vld),
        .push_data (result),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // The bone count never passes the limit.
    a_bone_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bone_count_reg <= BONE_LIMIT)
        else $error("bone count beyond limit");

    // The stack level never passes the stack depth.
    a_stack_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    // A settled parent is always a bone that was already composed.
    a_parent_precedes: assert property (@(posedge aclk) disable iff (!aresetn)
        (bone_count_reg != '0) && !pop_pending_reg
        |-> (CW'(parent_bone_reg) < bone_count_reg))
        else $error("parent bone not yet composed");

    // A result is only offered while a bone item is outstanding.
    a_result_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (out_cnt_reg != '0))
        else $error("result without outstanding item");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for skeleton_matrix_compose. A bench-side model
// composes every bone column as it is accepted and queues the expected
// result, and a checker compares each result field by field. The tests are
// a directed part (extremes, root flags, stack underflow), runs past the
// bone limit, random skeletons with noise, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     MAX_BONES    = 64;
    localparam int     STACK_DEPTH  = 64;
    localparam int     FRAC         = 16;
    localparam longint FRAC_MASK    = (64'sd1 <<< FRAC) - 1;
    localparam smc_pkg::word_t W_MAX = 32'sh7FFF_FFFF;
    localparam smc_pkg::word_t W_MIN = 32'sh8000_0000;
    localparam smc_pkg::word_t W_ONE = 32'sh0001_0000;
    localparam int     RANDOM_END   = 830;
    localparam int     LIMIT_CYCLES = 200000;
    localparam int     MAX_PRINTS   = 30;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    smc_pkg::in_item_t   s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    smc_pkg::out_item_t  m_data;

    // Bench-side copy of the composer state.
    smc_pkg::mat_t  ancestor_mat;
    smc_pkg::mat_t  model_mat [MAX_BONES];
    logic [3:0]     col_written [MAX_BONES];
    logic [5:0]     parent_stk [STACK_DEPTH];
    int             stk_level;
    int             cur_parent;
    int             bones_done;

    smc_pkg::out_item_t  expected_cols [$];
    smc_pkg::out_item_t  want;

    // Run controls and statistics.
    bit         idle_tx = 1'b1;
    bit         idle_rx = 1'b1;
    int         hold_req = 0;
    int         n_items = 0;
    int         n_ancestor = 0;
    int         n_results = 0;
    int         n_errors = 0;
    int         n_limit = 0;
    int         n_underflow = 0;
    int         n_sat = 0;
    int         cycles = 0;

    skeleton_matrix_compose #(
        .MAX_BONES   (MAX_BONES),
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycles, expected_cols.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint wanted);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("Mismatch in %s at result %0d: got %0d, expected %0d",
                     what, n_results, got, wanted);
    endtask

    // One element of P * L: the four full products are summed with their
    // fraction parts kept apart, rounded half up, then saturated.
    function automatic smc_pkg::word_t compose_row(input smc_pkg::mat_t par, input int row,
                                                   input smc_pkg::vec_t loc,
                                                   output bit clipped);
        longint whole;
        longint frac;
        longint prod;
        whole   = 0;
        frac    = 64'sd1 <<< (FRAC - 1);
        clipped = 1'b0;
        for (int k = 0; k < 4; k++) begin
            prod  = longint'($signed(par[k][row])) * longint'($signed(loc[k]));
            whole += prod >>> FRAC;
            frac  += prod & FRAC_MASK;
        end
        whole += frac >>> FRAC;
        if (whole > longint'(W_MAX)) begin
            clipped = 1'b1;
            return W_MAX;
        end
        if (whole < longint'(W_MIN)) begin
            clipped = 1'b1;
            return W_MIN;
        end
        return smc_pkg::word_t'(whole);
    endfunction

    // Applies one accepted item to the bench state and queues its result.
    task automatic predict_item(input smc_pkg::in_item_t it);
        smc_pkg::out_item_t res;
        smc_pkg::vec_t      loc;
        smc_pkg::vec_t      cv;
        smc_pkg::mat_t      par;
        int                 bone;
        bit                 err;
        bit                 clipped;
        loc = {it.e3, it.e2, it.e1, it.e0};
        err = 1'b0;
        if (it.op == smc_pkg::OP_ANCESTOR) begin
            ancestor_mat[it.column] = loc;
            bones_done    = 0;
            stk_level     = 1;
            parent_stk[0] = '0;
            cur_parent    = 0;
            n_ancestor++;
            return;
        end
        res = '0;
        res.out_column = it.column;
        if (bones_done >= MAX_BONES) begin
            // Past the bone limit nothing is stored and no state moves.
            res.bone        = smc_pkg::LIMIT_BONE;
            res.stack_error = 1'b1;
            n_limit++;
        end else begin
            bone = bones_done;
            par  = (bone == 0) ? ancestor_mat : model_mat[cur_parent];
            for (int r = 0; r < 4; r++) begin
                cv[r] = compose_row(par, r, loc, clipped);
                if (clipped)
                    n_sat++;
            end
            model_mat[bone][it.column]   = cv;
            col_written[bone][it.column] = 1'b1;
            res.c0 = cv[0];
            res.c1 = cv[1];
            res.c2 = cv[2];
            res.c3 = cv[3];
            // The translation column closes the bone; the root ignores flags.
            if (it.column == smc_pkg::COL_TRANSLATION) begin
                if (bone != 0) begin
                    if (it.push_req) begin
                        // A full stack cannot be reached at the default sizes.
                        if (stk_level >= STACK_DEPTH) begin
                            err = 1'b1;
                        end else begin
                            parent_stk[stk_level] = 6'(cur_parent);
                            stk_level++;
                        end
                    end
                    cur_parent = bone;
                    if (it.pop_req) begin
                        if (stk_level == 0) begin
                            err = 1'b1;
                            n_underflow++;
                        end else begin
                            stk_level--;
                            cur_parent = parent_stk[stk_level];
                        end
                    end
                end
                bones_done++;
            end
            res.bone        = 6'(bone);
            res.stack_error = err;
        end
        expected_cols.push_back(res);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_cols.size() == 0) begin
                report_mismatch("result with none expected", m_data.bone, -1);
            end else begin
                want = expected_cols.pop_front();
                if (m_data.bone !== want.bone)
                    report_mismatch("bone", m_data.bone, want.bone);
                if (m_data.out_column !== want.out_column)
                    report_mismatch("out_column", m_data.out_column, want.out_column);
                if (m_data.c0 !== want.c0)
                    report_mismatch("c0", m_data.c0, want.c0);
                if (m_data.c1 !== want.c1)
                    report_mismatch("c1", m_data.c1, want.c1);
                if (m_data.c2 !== want.c2)
                    report_mismatch("c2", m_data.c2, want.c2);
                if (m_data.c3 !== want.c3)
                    report_mismatch("c3", m_data.c3, want.c3);
                if (m_data.stack_error !== want.stack_error)
                    report_mismatch("stack_error", m_data.stack_error, want.stack_error);
            end
        end
    end

    // Receiver: a random stall per item if idle_rx, plus a long hold when asked.
    initial begin
        int stall;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall    = (idle_rx ? $urandom_range(3) : 0) + hold_req;
            hold_req = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Element values biased toward the edges of the Q16.16 range and ties.
    function automatic smc_pkg::word_t rand_word();
        case ($urandom_range(9))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3: return -1;
            4: return W_ONE;
            5: return -W_ONE;
            6: return 32'sh0000_8000;
            7: return smc_pkg::word_t'($urandom_range(32'h3_FFFF)) - 32'sh2_0000;
            default: return smc_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic smc_pkg::in_item_t random_item(input logic op, input logic [1:0] col);
        smc_pkg::in_item_t it;
        it.op       = op;
        it.column   = col;
        it.e0       = rand_word();
        it.e1       = rand_word();
        it.e2       = rand_word();
        it.e3       = rand_word();
        it.push_req = 1'($urandom_range(1));
        it.pop_req  = 1'($urandom_range(1));
        return it;
    endfunction

    // A bone may be closed only once its other columns hold defined values,
    // so that no later child reads an unwritten parent column.
    function automatic bit can_close();
        if (bones_done >= MAX_BONES)
            return 1'b1;
        return &col_written[bones_done][2:0];
    endfunction

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input smc_pkg::in_item_t it);
        int gap;
        gap = idle_tx ? $urandom_range(3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        predict_item(it);
    endtask

    task automatic send_words(input logic op, input logic [1:0] col,
                              input smc_pkg::word_t w0, input smc_pkg::word_t w1,
                              input smc_pkg::word_t w2, input smc_pkg::word_t w3,
                              input logic push, input logic pop);
        smc_pkg::in_item_t it;
        it = '{op: op, column: col, e0: w0, e1: w1, e2: w2, e3: w3,
               push_req: push, pop_req: pop};
        send_item(it);
    endtask

    // A whole bone: columns 0..2 in a random order, sometimes one repeated,
    // then the translation column with the given flags.
    task automatic send_bone(input bit push, input bit pop);
        smc_pkg::in_item_t it;
        int                start;
        int                stride;
        start  = $urandom_range(2);
        stride = $urandom_range(1, 2);
        for (int i = 0; i < 3; i++)
            send_item(random_item(smc_pkg::OP_BONE, 2'((start + i * stride) % 3)));
        if ($urandom_range(3) == 0)
            send_item(random_item(smc_pkg::OP_BONE, 2'($urandom_range(2))));
        it          = random_item(smc_pkg::OP_BONE, smc_pkg::COL_TRANSLATION);
        it.push_req = push;
        it.pop_req  = pop;
        send_item(it);
    endtask

    // Only the translation column when the bone index was written before.
    task automatic send_bone_short(input bit push, input bit pop);
        smc_pkg::in_item_t it;
        if (can_close()) begin
            it          = random_item(smc_pkg::OP_BONE, smc_pkg::COL_TRANSLATION);
            it.push_req = push;
            it.pop_req  = pop;
            send_item(it);
        end else begin
            send_bone(push, pop);
        end
    endtask

    task automatic load_ancestor(input int ncols);
        for (int i = 0; i < ncols; i++)
            send_item(random_item(smc_pkg::OP_ANCESTOR, 2'($urandom_range(3))));
    endtask

    // Random content with a bad column 3 turned into another column.
    task automatic send_noise();
        smc_pkg::in_item_t it;
        it = random_item(1'($urandom_range(1)), 2'($urandom_range(3)));
        if (it.op == smc_pkg::OP_BONE && it.column == smc_pkg::COL_TRANSLATION
            && !can_close())
            it.column = 2'($urandom_range(2));
        send_item(it);
    endtask

    // Extremes, saturation, root flags and a walk down to stack underflow.
    task automatic test_directed();
        // Bone 0 against the identity ancestor from reset, root flags set.
        send_words(smc_pkg::OP_BONE, 2'd0, W_MAX, W_MIN, '0, -1, 1'b1, 1'b1);
        send_words(smc_pkg::OP_BONE, 2'd1, -1, '0, W_MAX, W_MIN, 1'b1, 1'b1);
        send_words(smc_pkg::OP_BONE, 2'd2, 32'sh0000_8000, -32'sh0000_8000, W_ONE, 1,
                   1'b0, 1'b1);
        send_words(smc_pkg::OP_BONE, smc_pkg::COL_TRANSLATION, W_MIN, W_MAX, -W_ONE,
                   W_ONE, 1'b1, 1'b1);
        // An extreme ancestor; its translation column stays identity.
        send_words(smc_pkg::OP_ANCESTOR, 2'd0, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0, 1'b0);
        send_words(smc_pkg::OP_ANCESTOR, 2'd1, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1, 1'b1);
        send_words(smc_pkg::OP_ANCESTOR, 2'd2, 1, -1, W_ONE, -32'sh0000_8000, 1'b0, 1'b1);
        // Bone 0 again: saturation both ways, then close it with flags set.
        send_words(smc_pkg::OP_BONE, 2'd1, W_MAX, '0, '0, '0, 1'b1, 1'b0);
        send_words(smc_pkg::OP_BONE, smc_pkg::COL_TRANSLATION, '0, W_MAX, 32'sh0000_8000,
                   1, 1'b1, 1'b1);
        // Push, pop back to the root, pop the root, then pop an empty stack.
        send_bone(1'b1, 1'b0);
        send_bone(1'b0, 1'b1);
        send_bone(1'b0, 1'b1);
        send_bone(1'b0, 1'b1);
    endtask

    // Skeletons that run past the bone limit, once with idling, once without.
    task automatic test_bone_limit();
        for (int pass = 0; pass < 2; pass++) begin
            idle_tx = (pass == 0);
            idle_rx = (pass == 0);
            load_ancestor(4);
            for (int b = 0; b < MAX_BONES; b++)
                send_bone_short($urandom_range(99) < 50, $urandom_range(99) < 45);
            repeat (6)
                send_item(random_item(smc_pkg::OP_BONE, 2'($urandom_range(3))));
        end
        idle_tx = 1'b1;
        idle_rx = 1'b1;
    endtask

    // Mostly well-formed skeletons with random content, some noise bursts.
    task automatic test_random_skeletons();
        int nbones;
        while (n_items < RANDOM_END) begin
            idle_tx = ($urandom_range(3) != 0);
            idle_rx = ($urandom_range(3) != 0);
            if ($urandom_range(9) != 0)
                load_ancestor(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 4);
            nbones = ($urandom_range(9) == 0) ? $urandom_range(40, 70)
                                              : $urandom_range(1, 12);
            for (int b = 0; b < nbones; b++) begin
                if (n_items >= RANDOM_END)
                    break;
                if ($urandom_range(2) == 0)
                    send_bone($urandom_range(99) < 50, $urandom_range(99) < 45);
                else
                    send_bone_short($urandom_range(99) < 50, $urandom_range(99) < 45);
            end
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 6)) send_noise();
        end
        idle_tx = 1'b1;
        idle_rx = 1'b1;
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        idle_tx  = 1'b0;
        hold_req = 80;
        load_ancestor(4);
        repeat (16)
            send_bone_short($urandom_range(1), $urandom_range(1));
        idle_tx = 1'b1;
    endtask

    initial begin
        // Predicted state after reset.
        for (int k = 0; k < 4; k++)
            for (int r = 0; r < 4; r++)
                ancestor_mat[k][r] = (k == r) ? W_ONE : '0;
        for (int b = 0; b < MAX_BONES; b++)
            col_written[b] = '0;
        parent_stk[0] = '0;
        stk_level     = 1;
        cur_parent    = 0;
        bones_done    = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_bone_limit();
        test_random_skeletons();
        test_backpressure();

        s_valid <= 1'b0;
        while (expected_cols.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d items (%0d ancestor columns) and checked %0d bone columns.",
                 n_items, n_ancestor, n_results);
        $display("Bone limit hits %0d, stack underflows %0d, saturated elements %0d.",
                 n_limit, n_underflow, n_sat);
        if (n_errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/core/smc_pkg.sv
rtl/core/smc_column_mac.sv
rtl/core/smc_result_fifo.sv
rtl/core/skeleton_matrix_compose.sv
dv/testbench.sv
